FILE: hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared sizes, operation codes and control types for the NFA stepper.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int NUM_STATES  = 16;
   localparam int SYMBOL_BITS = 8;

   localparam int STATE_BITS  = $clog2(NUM_STATES);
   localparam int NUM_SYMBOLS = 1 << SYMBOL_BITS;
   localparam int ADDR_BITS   = STATE_BITS + SYMBOL_BITS;
   localparam int TABLE_DEPTH = NUM_STATES * NUM_SYMBOLS;

   // Field widths of the request beats.
   localparam int OP_W    = 2;
   localparam int SRC_W   = 4;
   localparam int DST_W   = 4;
   localparam int SYM_W   = 8;

   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
   localparam logic [OP_W-1:0] OP_ACCEPT  = 2'd2;
   localparam logic [OP_W-1:0] OP_PROCESS = 2'd3;

   typedef logic [NUM_STATES-1:0] state_set_type;

   // Commands from the sequencer to the table and accumulate unit.
   typedef struct packed {
      logic                 rd_en;
      logic                 take;
      logic                 wr_en;
      logic                 wr_clear;
      logic                 acc_clr;
      logic [ADDR_BITS-1:0] addr;
      state_set_type        dst_mask;
   } tbl_ctrl_type;

endpackage

FILE: hdl/nps_if.sv
// ----------------------------------------------------------------------------
// nps_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface nps_req_if;
   import nps_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [SRC_W-1:0] src_state;
   logic [DST_W-1:0] dst_state;
   logic [SYM_W-1:0] symbol;
   logic             first;

   modport source (output valid, op, src_state, dst_state, symbol, first, input ready);
   modport sink   (input valid, op, src_state, dst_state, symbol, first, output ready);
endinterface

interface nps_rsp_if;
   logic valid;
   logic ready;
   logic prefix_accepted;

   modport source (output valid, prefix_accepted, input ready);
   modport sink   (input valid, prefix_accepted, output ready);
endinterface

FILE: hdl/nfa_prefix_match_stepper.sv
// ----------------------------------------------------------------------------
// nfa_prefix_match_stepper
// NFA active-state-set stepper over a byte stream with a loadable table.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time and is not ready while it works.
// A process-symbol beat reads the transition memory once per state, one row
// per cycle through a single read port, before the next beat can be taken; its
// response sits in an output register and does not hold up the next request,
// but a later process-symbol beat waits at the end of its scan until that
// response has been taken.
// Adding a transition is a read-modify-write of one row, a read state and then
// a write state; marking an accepting state sets a bit in a register while
// idle. After reset and after each clear request the block sweeps the whole
// transition memory, one row per cycle, clearing all 4096 rows, before it
// is ready again.
module nfa_prefix_match_stepper (
   input  logic       clock,
   input  logic       reset,
   nps_req_if.sink    req_bus,
   nps_rsp_if.source  rsp_bus
);
   import nps_pkg::*;

   tbl_ctrl_type  ctrl;
   state_set_type acc_set;

   nps_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .ctrl    (ctrl),
      .acc_set (acc_set)
   );

   nps_table u_table (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .acc_set (acc_set)
   );

endmodule

FILE: hdl/nps_table.sv
// ----------------------------------------------------------------------------
// nps_table
// Transition memory with its read-modify-write path and the successor
// accumulator that ORs the taken table rows, one per cycle, into the next state set.
// ----------------------------------------------------------------------------
module nps_table (
   input  logic                  clock,
   input  logic                  reset,
   input  nps_pkg::tbl_ctrl_type ctrl,
   output nps_pkg::state_set_type acc_set
);
   import nps_pkg::*;

   state_set_type mem [TABLE_DEPTH];
   state_set_type rd_data_ff;
   state_set_type acc_ff;
   state_set_type acc_in;
   state_set_type wr_data;
   logic          take_ff;
   logic          take_in;

   // A transition is added by setting one bit in the row read in the cycle before.
   assign wr_data = ctrl.wr_clear ? '0 : (rd_data_ff | ctrl.dst_mask);

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.addr];
      end
   end

   assign take_in = ctrl.rd_en & ctrl.take;

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff <= 1'b0;
      end else begin
         take_ff <= take_in;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_clr) begin
         acc_in = '0;
      end else if (take_ff) begin
         acc_in = acc_ff | rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_set = acc_ff;

endmodule

FILE: hdl/nps_seq.sv
// ----------------------------------------------------------------------------
// nps_seq
// Sequencer: takes request beats, steps the table through clearing,
// transition updates and successor scans, and holds the response register.
// ----------------------------------------------------------------------------
module nps_seq (
   input  logic                   clock,
   input  logic                   reset,
   nps_req_if.sink                req_bus,
   nps_rsp_if.source              rsp_bus,
   output nps_pkg::tbl_ctrl_type  ctrl,
   input  nps_pkg::state_set_type acc_set
);
   import nps_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_ADD_RD = 6'b000100,
      ST_ADD_WR = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_DONE   = 6'b100000
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [STATE_BITS-1:0] scan_ff, scan_in;
   logic                 flush_ff, flush_in;
   state_set_type        active_ff, active_in;
   state_set_type        accept_ff, accept_in;
   state_set_type        cur_ff, cur_in;
   state_set_type        dst_mask_ff, dst_mask_in;
   logic [STATE_BITS-1:0] src_ff, src_in;
   logic [SYMBOL_BITS-1:0] sym_ff, sym_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 src_ok;
   logic                 dst_ok;
   logic                 rsp_free;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign src_ok        = int'(req_bus.src_state) < NUM_STATES;
   assign dst_ok        = int'(req_bus.dst_state) < NUM_STATES;
   assign rsp_free      = ~rsp_valid_ff | rsp_bus.ready;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.prefix_accepted = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      flush_in     = 1'b0;
      active_in    = active_ff;
      accept_in    = accept_ff;
      cur_in       = cur_ff;
      dst_mask_in  = dst_mask_ff;
      src_in       = src_ff;
      sym_in       = sym_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;

      ctrl          = '0;
      ctrl.dst_mask = dst_mask_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.wr_en    = 1'b1;
            ctrl.wr_clear = 1'b1;
            ctrl.addr     = clr_ff;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == ADDR_BITS'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               src_in      = STATE_BITS'(req_bus.src_state);
               sym_in      = req_bus.symbol[SYMBOL_BITS-1:0];
               dst_mask_in = state_set_type'(1) << req_bus.dst_state;
               unique case (req_bus.op)
                  OP_CLEAR: begin
                     active_in = '0;
                     accept_in = '0;
                     clr_in    = '0;
                     state_in  = ST_CLEAR;
                  end
                  OP_ADD: begin
                     if (src_ok && dst_ok) begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  OP_ACCEPT: begin
                     if (src_ok) begin
                        accept_in = accept_ff |
                                    (state_set_type'(1) << req_bus.src_state);
                     end
                  end
                  OP_PROCESS: begin
                     cur_in       = req_bus.first ? state_set_type'(1) : active_ff;
                     scan_in      = '0;
                     ctrl.acc_clr = 1'b1;
                     state_in     = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADD_RD: begin
            ctrl.rd_en = 1'b1;
            ctrl.addr  = {src_ff, sym_ff};
            state_in   = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            ctrl.wr_en = 1'b1;
            ctrl.addr  = {src_ff, sym_ff};
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            // Rows of inactive states are read but not merged.
            ctrl.rd_en = 1'b1;
            ctrl.take  = cur_ff[scan_ff];
            ctrl.addr  = {scan_ff, sym_ff};
            scan_in    = scan_ff + 1'b1;
            if (scan_ff == STATE_BITS'(NUM_STATES - 1)) begin
               flush_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The last row lands in the accumulator in the cycle after entry.
            if (!flush_ff && rsp_free) begin
               active_in    = acc_set;
               rsp_valid_in = 1'b1;
               rsp_data_in  = |(acc_set & accept_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         flush_ff     <= 1'b0;
         active_ff    <= '0;
         accept_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         flush_ff     <= flush_in;
         active_ff    <= active_in;
         accept_ff    <= accept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      dst_mask_ff <= dst_mask_in;
      src_ff      <= src_in;
      sym_ff      <= sym_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
